>>> rtl/lcd4_pkg.sv
// shared types, constants and the nibble sequence function for the 4-bit lcd sequencer
package lcd4_pkg;

   localparam int CMD_W       = 3;
   localparam int VALUE_W     = 8;
   localparam int ROW_W       = 3;
   localparam int NIB_W       = 4;
   localparam int PULSE_W     = 10;
   localparam int WAIT_W      = 14;
   localparam int BASE_W      = 7;
   localparam int ROWS        = 4;
   localparam int IDX_W       = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 10;
   localparam int QUEUE_DEPTH = 2;

   // request command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_INIT     = 3'd0,
      CMD_WR_CMD   = 3'd1,
      CMD_WR_DATA  = 3'd2,
      CMD_SET_POS  = 3'd3,
      CMD_GLYPH    = 3'd4
   } cmd_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW3  = 3'd4;

   // configuration reset values
   localparam logic [PULSE_W-1:0] PULSE_RESET = 10'd50;
   localparam logic [BASE_W-1:0]  ROW0_RESET  = 7'h00;
   localparam logic [BASE_W-1:0]  ROW1_RESET  = 7'h40;
   localparam logic [BASE_W-1:0]  ROW2_RESET  = 7'h14;
   localparam logic [BASE_W-1:0]  ROW3_RESET  = 7'h54;

   // instruction encodings
   localparam logic [VALUE_W-1:0] DDRAM_SET_BIT = 8'h80;
   localparam logic [1:0]         CGRAM_PREFIX  = 2'b01;

   // init sequence timing
   localparam logic [WAIT_W-1:0] WAIT_POWER_ON = 14'd15000;
   localparam logic [WAIT_W-1:0] WAIT_SECOND   = 14'd4000;
   localparam logic [WAIT_W-1:0] WAIT_THIRD    = 14'd100;
   localparam logic [WAIT_W-1:0] WAIT_STEP     = 14'd1000;
   localparam logic [IDX_W-1:0]  INIT_LAST_IDX = 4'd9;

   // one queued job between front and back
   typedef struct packed {
      logic               init;
      logic               rs;
      logic [VALUE_W-1:0] data;
   } entry_type;

   // one enable pulse description
   typedef struct packed {
      logic              rs;
      logic [NIB_W-1:0]  nibble;
      logic [WAIT_W-1:0] lead;
      logic [WAIT_W-1:0] after;
      logic              last;
   } nib_type;

   // nibble at position idx of a job
   function automatic nib_type make_nibble(entry_type job, logic [IDX_W-1:0] idx);
      nib_type n;
      n = '0;
      if (job.init) begin
         n.rs = 1'b0;
         case (idx)
            4'd0: begin
               n.nibble = 4'h3;
               n.lead   = WAIT_POWER_ON;
            end
            4'd1: begin
               n.nibble = 4'h3;
               n.lead   = WAIT_SECOND;
            end
            4'd2: begin
               n.nibble = 4'h3;
               n.lead   = WAIT_THIRD;
            end
            4'd3: begin
               n.nibble = 4'h2;
               n.lead   = WAIT_STEP;
            end
            // function set 0x28
            4'd4: begin
               n.nibble = 4'h2;
               n.lead   = WAIT_STEP;
            end
            4'd5: begin
               n.nibble = 4'h8;
            end
            // display on 0x0c
            4'd6: begin
               n.nibble = 4'h0;
               n.lead   = WAIT_STEP;
            end
            4'd7: begin
               n.nibble = 4'hC;
            end
            // entry mode 0x06
            4'd8: begin
               n.nibble = 4'h0;
               n.lead   = WAIT_STEP;
            end
            INIT_LAST_IDX: begin
               n.nibble = 4'h6;
               n.after  = WAIT_STEP;
               n.last   = 1'b1;
            end
            default: begin
               n = '0;
            end
         endcase
      end else begin
         n.rs = job.rs;
         if (idx == '0) begin
            n.nibble = job.data[VALUE_W-1:NIB_W];
         end else begin
            n.nibble = job.data[NIB_W-1:0];
            n.last   = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

>>> rtl/lcd4_queue.sv
// short job queue between the request front and the nibble back end
module lcd4_queue
   import lcd4_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      head_valid,
   output logic      full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

   entry_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head       = slot_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CntW'(Depth));

   // no push into a full queue without a pop in the same cycle, no pop from an empty one
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid)) else $error("queue pop while empty");
   // fill count never passes the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth)) else $error("queue count out of range");

endmodule

>>> rtl/lcd4_front.sv
// request front end: accepts requests and turns them into queued byte or init jobs
module lcd4_front
   import lcd4_pkg::*;
(
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [CMD_W-1:0]             req_command,
   input  logic [VALUE_W-1:0]           req_value,
   input  logic [ROW_W-1:0]             req_row,
   input  logic [ROWS-1:0][BASE_W-1:0]  row_base,
   input  logic                         q_full,
   output logic                         push,
   output entry_type                    push_entry
);

   logic               accept;
   logic               known;
   logic [VALUE_W-1:0] base;
   logic [VALUE_W-1:0] pos_sum;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // row base lookup, rows past the last fall back to zero
   always_comb begin
      if (req_row < ROW_W'(ROWS)) begin
         base = {1'b0, row_base[req_row[1:0]]};
      end else begin
         base = '0;
      end
      pos_sum = base + req_value;
   end

   // classify the request
   always_comb begin
      known      = 1'b1;
      push_entry = '0;
      case (req_command)
         CMD_INIT: begin
            push_entry.init = 1'b1;
         end
         CMD_WR_CMD: begin
            push_entry.data = req_value;
         end
         CMD_WR_DATA: begin
            push_entry.rs   = 1'b1;
            push_entry.data = req_value;
         end
         CMD_SET_POS: begin
            push_entry.data = pos_sum | DDRAM_SET_BIT;
         end
         CMD_GLYPH: begin
            push_entry.data = {CGRAM_PREFIX, req_value[2:0], 3'b000};
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

   // unknown commands are taken and dropped
   assign push = accept && known;

endmodule

>>> rtl/lcd4_back.sv
// nibble back end: walks each queued job and drives one enable pulse per transaction
module lcd4_back
   import lcd4_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  entry_type           q_head,
   output logic                q_pop,
   input  logic [PULSE_W-1:0]  pulse_cfg,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_rs,
   output logic [NIB_W-1:0]    rsp_nibble,
   output logic [PULSE_W-1:0]  rsp_pulse_us,
   output logic [WAIT_W-1:0]   rsp_wait_before_us,
   output logic [WAIT_W-1:0]   rsp_wait_after_us,
   output logic                rsp_last
);

   logic             active_ff, active_in;
   entry_type        cur_ff, cur_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   nib_type          out_ff, out_in;
   logic [PULSE_W-1:0] pulse_ff, pulse_in;

   entry_type        sel_entry;
   logic [IDX_W-1:0] sel_idx;
   logic             out_free;
   logic             emit;
   nib_type          nib;
   logic [PULSE_W-1:0] pulse_eff;

   // pick the running job, or start the queue head at its first nibble
   always_comb begin
      sel_entry = active_ff ? cur_ff : q_head;
      sel_idx   = active_ff ? idx_ff : '0;
      out_free  = !rsp_valid_ff || rsp_ready;
      emit      = out_free && (active_ff || q_valid);
      q_pop     = out_free && !active_ff && q_valid;
      nib       = make_nibble(sel_entry, sel_idx);
      pulse_eff = (pulse_cfg == '0) ? PULSE_W'(1) : pulse_cfg;
   end

   // job walker and output register
   always_comb begin
      active_in    = active_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      out_in       = out_ff;
      pulse_in     = pulse_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         active_in    = !nib.last;
         cur_in       = sel_entry;
         idx_in       = sel_idx + 1'b1;
         out_in       = nib;
         pulse_in     = pulse_eff;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      out_ff   <= out_in;
      pulse_ff <= pulse_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rs             = out_ff.rs;
   assign rsp_nibble         = out_ff.nibble;
   assign rsp_pulse_us       = pulse_ff;
   assign rsp_wait_before_us = out_ff.lead;
   assign rsp_wait_after_us  = out_ff.after;
   assign rsp_last           = out_ff.last;

   // a running job has already sent its first nibble
   a_active_idx: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (idx_ff != '0)) else $error("running job at first nibble");
   // a byte job is only ever left running before its low nibble
   a_byte_idx: assert property (@(posedge clock) disable iff (reset)
      (active_ff && !cur_ff.init) |-> (idx_ff == IDX_W'(1)))
      else $error("byte job past low nibble");
   // the final nibble closes the job
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (emit && nib.last) |=> !active_ff) else $error("job still running after last");

endmodule

>>> rtl/char_lcd_4bit_sequencer_core.sv
// top level of the 4-bit character lcd sequencer: config registers, front, queue, back
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | command, value, row
//  rsp     | out       | rsp_valid / rsp_ready | rs, nibble, pulse_us, wait_before_us,
//          |           |                       | wait_after_us, last
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// the back end puts out one nibble transaction per cycle unless rsp stalls or no job waits:
// bytes go high nibble first, init walks its sequence; the output register sets the rate.
// the front takes a request every cycle while the job queue has room.
// synchronous reset clears control state and loads the register defaults; no clearing pass.
// a stalled rsp holds the output register; the queue absorbs requests until full.
// csr_ready is always high; unknown commands and csr indexes are taken and ignored.
module char_lcd_4bit_sequencer_core
   import lcd4_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [VALUE_W-1:0]    req_value,
   input  logic [ROW_W-1:0]      req_row,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_rs,
   output logic [NIB_W-1:0]      rsp_nibble,
   output logic [PULSE_W-1:0]    rsp_pulse_us,
   output logic [WAIT_W-1:0]     rsp_wait_before_us,
   output logic [WAIT_W-1:0]     rsp_wait_after_us,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [PULSE_W-1:0]            pulse_ff;
   logic [ROWS-1:0][BASE_W-1:0]   base_ff;

   logic      q_full;
   logic      q_push;
   entry_type q_push_entry;
   logic      q_pop;
   entry_type q_head;
   logic      q_valid;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff   <= PULSE_RESET;
         base_ff[0] <= ROW0_RESET;
         base_ff[1] <= ROW1_RESET;
         base_ff[2] <= ROW2_RESET;
         base_ff[3] <= ROW3_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PULSE: pulse_ff   <= csr_wdata[PULSE_W-1:0];
            CSR_ROW0:  base_ff[0] <= csr_wdata[BASE_W-1:0];
            CSR_ROW1:  base_ff[1] <= csr_wdata[BASE_W-1:0];
            CSR_ROW2:  base_ff[2] <= csr_wdata[BASE_W-1:0];
            CSR_ROW3:  base_ff[3] <= csr_wdata[BASE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // request classification
   lcd4_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_command(req_command),
      .req_value  (req_value),
      .req_row    (req_row),
      .row_base   (base_ff),
      .q_full     (q_full),
      .push       (q_push),
      .push_entry (q_push_entry)
   );

   // job queue
   lcd4_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_push_entry),
      .pop       (q_pop),
      .head      (q_head),
      .head_valid(q_valid),
      .full      (q_full)
   );

   // nibble sequencing
   lcd4_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .pulse_cfg         (pulse_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_rs            (rsp_rs),
      .rsp_nibble        (rsp_nibble),
      .rsp_pulse_us      (rsp_pulse_us),
      .rsp_wait_before_us(rsp_wait_before_us),
      .rsp_wait_after_us (rsp_wait_after_us),
      .rsp_last          (rsp_last)
   );

endmodule
